>>> sv/cdc_pkg.sv
// Shared types, calendar tables and constants for the day-of-year converter.
`timescale 1ns / 1ps

package cdc_pkg;

    localparam logic ReqForward = 1'b0;
    localparam logic ReqReverse = 1'b1;

    localparam int YearWidth = 14;
    localparam int RecipWidth = 13;
    localparam int ProdWidth = YearWidth + RecipWidth;
    localparam int DivShift = 19;
    localparam int QuotWidth = ProdWidth - DivShift;

    localparam logic [RecipWidth-1:0] CenturyRecip = 13'd5243;
    localparam logic [YearWidth:0] CenturyLen = 15'd100;
    localparam logic [3:0] MonthsPerYear = 4'd12;
    localparam logic [8:0] CommonYearLen = 9'd365;

    typedef struct packed {
        logic       req_type;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [8:0] day_number;
    } cdc_req_t;

    typedef struct packed {
        cdc_req_t req;
        logic     leap;
    } cdc_leap_t;

    typedef struct packed {
        logic       req_type;
        logic       bad;
        logic [4:0] day_of_month;
        logic [8:0] day_number;
        logic [3:0] month;
        logic [8:0] base;
    } cdc_match_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] cum_before(input logic leap, input logic [3:0] m);
        logic [8:0] days;
        case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        if (leap && m >= 4'd3 && m <= MonthsPerYear)
        begin
            days = days + 9'd1;
        end
        return days;
    endfunction

endpackage

>>> sv/calendar_day_of_year_converter.sv
// Gregorian day-of-year converter: date to day number and day number to date.
// An accepted request passes through the two leap-year stages, the table stage and the result register.
// Throughput is one transaction per cycle while res_stall is low; each stage holds while the one after it is held.
// The leap-year stages, the table stage and the result register make up the four-stage depth.
// Reset clears all valid bits asynchronously; payload registers are not reset.
`timescale 1ns / 1ps

module calendar_day_of_year_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    input  logic [8:0]  day_number,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [8:0]  result_day_number,
    output logic [3:0]  result_month,
    output logic [4:0]  result_day,
    output logic        invalid
);
    import cdc_pkg::*;

    cdc_req_t   req;
    cdc_leap_t  leap_data;
    cdc_match_t match_data;
    logic       leap_valid;
    logic       match_en;
    logic       match_valid;
    logic       result_en;

    assign req.req_type = req_type;
    assign req.month = month;
    assign req.day_of_month = day_of_month;
    assign req.day_number = day_number;

    cdc_leap u_leap (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_valid),
        .in_stall (req_stall),
        .in_req   (req),
        .in_year  (year),
        .out_valid(leap_valid),
        .out_en   (match_en),
        .out_data (leap_data)
    );

    cdc_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (leap_valid),
        .in_en    (match_en),
        .in_data  (leap_data),
        .out_valid(match_valid),
        .out_en   (result_en),
        .out_data (match_data)
    );

    cdc_result u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (match_valid),
        .in_en            (result_en),
        .in_data          (match_data),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .result_day_number(result_day_number),
        .result_month     (result_month),
        .result_day       (result_day),
        .invalid          (invalid)
    );

endmodule

>>> sv/cdc_leap.sv
// Two pipeline stages that work out the Gregorian leap-year flag of each request.
`timescale 1ns / 1ps

module cdc_leap (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cdc_pkg::cdc_req_t   in_req,
    input  logic [13:0]         in_year,
    output logic                out_valid,
    input  logic                out_en,
    output cdc_pkg::cdc_leap_t  out_data
);
    import cdc_pkg::*;

    logic                 s1_valid_reg;
    cdc_req_t             s1_req_reg;
    logic [YearWidth-1:0] s1_year_reg;
    logic [QuotWidth-1:0] s1_quot_reg;
    logic                 s2_valid_reg;
    cdc_leap_t            s2_data_reg;

    logic                 en1;
    logic                 en2;
    logic [ProdWidth-1:0] prod;
    logic [YearWidth:0]   rem_century;
    logic                 div100;
    logic                 div4;
    cdc_leap_t            s2_data_next;

    assign en2 = !s2_valid_reg || out_en;
    assign en1 = !s1_valid_reg || en2;
    assign in_stall = !en1;

    assign prod = ProdWidth'(in_year) * ProdWidth'(CenturyRecip);

    always_comb
    begin
        rem_century = {1'b0, s1_year_reg} - (YearWidth + 1)'(s1_quot_reg) * CenturyLen;
        div100 = (rem_century == '0);
        div4 = (s1_year_reg[1:0] == 2'b00);
        s2_data_next.req = s1_req_reg;
        s2_data_next.leap = div4 && (!div100 || s1_quot_reg[1:0] == 2'b00);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_req_reg <= in_req;
            s1_year_reg <= in_year;
            s1_quot_reg <= prod[ProdWidth-1:DivShift];
        end
        if (en2)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data = s2_data_reg;

endmodule

>>> sv/cdc_match.sv
// Range checks and month table lookup stage of the converter.
`timescale 1ns / 1ps

module cdc_match (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_en,
    input  cdc_pkg::cdc_leap_t   in_data,
    output logic                 out_valid,
    input  logic                 out_en,
    output cdc_pkg::cdc_match_t  out_data
);
    import cdc_pkg::*;

    logic       valid_reg;
    cdc_match_t data_reg;
    cdc_match_t data_next;

    logic       fwd_ok;
    logic       rev_ok;
    logic [8:0] year_len;
    logic [3:0] rev_month;
    logic [8:0] rev_base;

    assign in_en = !valid_reg || out_en;

    always_comb
    begin
        fwd_ok = (in_data.req.month != 4'd0) && (in_data.req.month <= MonthsPerYear)
            && (in_data.req.day_of_month != 5'd0)
            && (in_data.req.day_of_month <= month_len(in_data.leap, in_data.req.month));
        year_len = CommonYearLen + 9'(in_data.leap);
        rev_ok = (in_data.req.day_number != 9'd0) && (in_data.req.day_number <= year_len);
        rev_month = 4'd1;
        rev_base = 9'd0;
        for (int m = 2; m <= 12; m++)
        begin
            if (in_data.req.day_number > cum_before(in_data.leap, 4'(m)))
            begin
                rev_month = 4'(m);
                rev_base = cum_before(in_data.leap, 4'(m));
            end
        end
        data_next.req_type = in_data.req.req_type;
        data_next.day_of_month = in_data.req.day_of_month;
        data_next.day_number = in_data.req.day_number;
        if (in_data.req.req_type == ReqReverse)
        begin
            data_next.bad = !rev_ok;
            data_next.month = rev_month;
            data_next.base = rev_base;
        end
        else
        begin
            data_next.bad = !fwd_ok;
            data_next.month = in_data.req.month;
            data_next.base = cum_before(in_data.leap, in_data.req.month);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

>>> sv/cdc_result.sv
// Final stage that forms the day number or month and day and holds the result.
`timescale 1ns / 1ps

module cdc_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_en,
    input  cdc_pkg::cdc_match_t  in_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [8:0]           result_day_number,
    output logic [3:0]           result_month,
    output logic [4:0]           result_day,
    output logic                 invalid
);
    import cdc_pkg::*;

    logic       valid_reg;
    logic [8:0] day_number_reg;
    logic [3:0] month_reg;
    logic [4:0] day_reg;
    logic       invalid_reg;

    logic [8:0] day_number_next;
    logic [3:0] month_next;
    logic [4:0] day_next;
    logic [8:0] fwd_sum;
    logic [8:0] rev_diff;

    assign in_en = !valid_reg || !res_stall;

    always_comb
    begin
        fwd_sum = in_data.base + 9'(in_data.day_of_month);
        rev_diff = in_data.day_number - in_data.base;
        day_number_next = 9'd0;
        month_next = 4'd0;
        day_next = 5'd0;
        if (!in_data.bad)
        begin
            if (in_data.req_type == ReqReverse)
            begin
                month_next = in_data.month;
                day_next = rev_diff[4:0];
            end
            else
            begin
                day_number_next = fwd_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            day_number_reg <= day_number_next;
            month_reg <= month_next;
            day_reg <= day_next;
            invalid_reg <= in_data.bad;
        end
    end

    assign res_valid = valid_reg;
    assign result_day_number = day_number_reg;
    assign result_month = month_reg;
    assign result_day = day_reg;
    assign invalid = invalid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && invalid) |->
            (result_day_number == 9'd0 && result_month == 4'd0 && result_day == 5'd0))
        else $error("invalid result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result_month != 4'd0) |->
            (result_day != 5'd0 && result_day_number == 9'd0 && !invalid))
        else $error("reverse result is malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !invalid && result_month == 4'd0) |-> (result_day_number != 9'd0))
        else $error("valid result has neither a day number nor a month");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (result_month <= MonthsPerYear && result_day_number <= 9'd366))
        else $error("result out of calendar range");

endmodule
